[rtl/sobol_sequence_generator_core_assert.svh]
// assertion macros shared by the rtl
`ifndef SOBOL_SEQUENCE_GENERATOR_CORE_ASSERT_SVH
`define SOBOL_SEQUENCE_GENERATOR_CORE_ASSERT_SVH

`ifndef ASSERT_OFF

`define SOBOL_ASSERT_IMPLY(lbl, clk, rst_n, a, c, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) \
        else $error(msg);

`define SOBOL_ASSERT_NEXT(lbl, clk, rst_n, a, c, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) \
        else $error(msg);

`else

`define SOBOL_ASSERT_IMPLY(lbl, clk, rst_n, a, c, msg)

`define SOBOL_ASSERT_NEXT(lbl, clk, rst_n, a, c, msg)

`endif

`endif

[rtl/sobol_pkg.sv]
package sobol_pkg;

    localparam int MAX_BITS_DEF   = 32;
    localparam int MAX_DEGREE_DEF = 18;
    localparam int POINT_W        = 32;
    // address field width, enough for the largest table
    localparam int TAB_AW         = 5;

    localparam logic [1:0] REQ_LOAD = 2'd0;
    localparam logic [1:0] REQ_PREP = 2'd1;
    localparam logic [1:0] REQ_NEXT = 2'd2;

    localparam logic [1:0] CFG_DEGREE = 2'd0;
    localparam logic [1:0] CFG_COEFFS = 2'd1;
    localparam logic [1:0] CFG_BITS   = 2'd2;
    localparam logic [1:0] CFG_IDENT  = 2'd3;

    typedef struct packed {
        logic [1:0]  req_type;
        logic [4:0]  load_index;
        logic [17:0] load_value;
    } sobol_req_t;

    typedef struct packed {
        logic [31:0] point;
        logic [31:0] point_index;
        logic        exhausted;
    } sobol_res_t;

    // table port driven by the prepare sequencer
    typedef struct packed {
        logic                busy;
        logic                we;
        logic [TAB_AW-1:0]   waddr;
        logic [POINT_W-1:0]  wdata;
        logic [TAB_AW-1:0]   raddr;
    } prep_port_t;

    // position of the lowest zero bit of a word
    function automatic logic [4:0] lowest_zero(input logic [31:0] cnt);
        logic [31:0] onehot;
        logic [4:0]  pos;
        onehot = ~cnt & (cnt + 32'd1);
        pos    = '0;
        for (int p = 0; p < 32; p++) begin
            if (onehot[p]) begin
                pos = pos | 5'(p);
            end
        end
        return pos;
    endfunction

endpackage

[rtl/sobol_sequence_generator_core.sv]
// One dimension of a Sobol sequence in Gray-code order, points scaled by 2^32.
// A next word is taken every cycle while busy is low; its result passes the
// pend and result-strobe registers and then strobes for one cycle. A load
// word gives no result. A prepare word holds busy while the direction table
// is rebuilt through the table's single read port: each entry below the
// degree (or every entry on the identity dimension) is written from FILL, and
// each recurrence entry goes through FILL, REC_RD per tap, REC_WAIT and REC_WR.
// The receiver cannot stall: each result strobe is high for one cycle only.
// Next words issued before the first prepare read an unwritten table.
`include "sobol_sequence_generator_core_assert.svh"

module sobol_sequence_generator_core
    import sobol_pkg::*;
#(
    parameter int MAX_BITS   = MAX_BITS_DEF,
    parameter int MAX_DEGREE = MAX_DEGREE_DEF
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  sobol_req_t  request,
    output logic        result_strobe,
    output sobol_res_t  result,
    input  logic        cfg_write,
    input  logic [1:0]  cfg_index,
    input  logic [16:0] cfg_data
);

    localparam int IDX_W = $clog2(MAX_BITS);
    localparam int DEG_W = (MAX_DEGREE > 1) ? $clog2(MAX_DEGREE) : 1;

    logic [4:0]  degree_reg;
    logic [16:0] coeffs_reg;
    logic [5:0]  bits_reg;
    logic        ident_reg;

    logic [17:0] init_m_reg [MAX_DEGREE];

    logic [POINT_W-1:0] dir_mem [MAX_BITS];
    logic [POINT_W-1:0] rd_data_reg;
    logic [IDX_W-1:0]   rd_addr;

    logic [31:0] point_reg, point_next;
    logic [31:0] cnt_reg;
    logic        exh_reg;
    logic [5:0]  lbits_reg;
    logic        pend_reg;
    logic        pend_adv_reg;
    logic        result_strobe_reg;
    sobol_res_t  result_reg;

    logic        accept;
    logic        do_load, do_prep, do_next;
    logic        adv;
    logic [32:0] last_idx;
    logic [32:0] cnt_inc;
    logic [4:0]  zpos;
    logic [4:0]  s_clamp;
    logic [5:0]  l_clamp;
    logic [4:0]  load_m1;
    logic [5:0]  m_idx;
    logic [17:0] m_value;
    logic [31:0] xor_point;

    prep_port_t  prep_port;

    assign accept  = start && !busy;
    assign do_load = accept && (request.req_type == REQ_LOAD);
    assign do_prep = accept && (request.req_type == REQ_PREP);
    assign do_next = accept && (request.req_type == REQ_NEXT);

    assign s_clamp = (degree_reg == 5'd0) ? 5'd1 :
                     (32'(degree_reg) > MAX_DEGREE) ? 5'(MAX_DEGREE) : degree_reg;
    assign l_clamp = (bits_reg == 6'd0) ? 6'd1 :
                     (32'(bits_reg) > MAX_BITS) ? 6'(MAX_BITS) : bits_reg;

    assign last_idx = (33'd1 << lbits_reg) - 33'd1;
    assign cnt_inc  = {1'b0, cnt_reg} + 33'd1;
    assign adv      = !exh_reg && ({1'b0, cnt_reg} < last_idx);
    assign zpos     = lowest_zero(cnt_reg);

    assign load_m1 = request.load_index - 5'd1;
    assign m_idx   = 6'(prep_port.waddr);
    assign m_value = (32'(m_idx) < MAX_DEGREE) ? init_m_reg[m_idx[DEG_W-1:0]] : '0;

    assign busy    = prep_port.busy;
    assign rd_addr = prep_port.busy ? prep_port.raddr[IDX_W-1:0] : zpos[IDX_W-1:0];

    assign xor_point = pend_adv_reg ? (point_reg ^ rd_data_reg) : point_reg;

    sobol_prep #(
        .MAX_BITS   (MAX_BITS)
    ) u_prep (
        .clk     (clk),
        .rst_n   (rst_n),
        .launch  (do_prep),
        .lbits   (lbits_reg),
        .degree  (s_clamp),
        .coeffs  (coeffs_reg),
        .ident   (ident_reg),
        .m_value (m_value),
        .rd_data (rd_data_reg),
        .port    (prep_port)
    );

    // direction table, one write and one registered read per cycle
    always_ff @(posedge clk)
    begin
        if (prep_port.we)
        begin
            dir_mem[prep_port.waddr[IDX_W-1:0]] <= prep_port.wdata;
        end
        rd_data_reg <= dir_mem[rd_addr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            degree_reg <= 5'd1;
            coeffs_reg <= '0;
            bits_reg   <= 6'd32;
            ident_reg  <= 1'b1;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                CFG_DEGREE: degree_reg <= cfg_data[4:0];
                CFG_COEFFS: coeffs_reg <= cfg_data;
                CFG_BITS:   bits_reg   <= cfg_data[5:0];
                CFG_IDENT:  ident_reg  <= cfg_data[0];
                default:    ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < MAX_DEGREE; i++)
            begin
                init_m_reg[i] <= '0;
            end
        end
        else if (do_load && (request.load_index != 5'd0)
                 && (32'(request.load_index) <= MAX_DEGREE))
        begin
            init_m_reg[load_m1[DEG_W-1:0]] <= request.load_value;
        end
    end

    // a prepare right behind a next still reports that next, then clears
    always_comb
    begin
        point_next = point_reg;
        if (do_prep)
        begin
            point_next = '0;
        end
        else if (pend_reg)
        begin
            point_next = xor_point;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            point_reg         <= '0;
            cnt_reg           <= '0;
            exh_reg           <= 1'b0;
            lbits_reg         <= 6'(MAX_BITS);
            pend_reg          <= 1'b0;
            pend_adv_reg      <= 1'b0;
            result_strobe_reg <= 1'b0;
        end
        else
        begin
            point_reg         <= point_next;
            pend_reg          <= do_next;
            pend_adv_reg      <= do_next && adv;
            result_strobe_reg <= pend_reg;
            if (do_prep)
            begin
                cnt_reg   <= '0;
                exh_reg   <= 1'b0;
                lbits_reg <= l_clamp;
            end
            else if (do_next)
            begin
                if (adv)
                begin
                    cnt_reg <= cnt_inc[31:0];
                    exh_reg <= (cnt_inc >= last_idx);
                end
                else
                begin
                    exh_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (pend_reg)
        begin
            result_reg.point       <= xor_point;
            result_reg.point_index <= cnt_reg;
            result_reg.exhausted   <= exh_reg;
        end
    end

    assign result_strobe = result_strobe_reg;
    assign result        = result_reg;

    `SOBOL_ASSERT_IMPLY(a_wr_in_prep, clk, rst_n, prep_port.we, busy,
        "table written outside a prepare")
    `SOBOL_ASSERT_IMPLY(a_strobe_src, clk, rst_n, result_strobe_reg, $past(pend_reg),
        "result strobe without a pending next word")
    `SOBOL_ASSERT_IMPLY(a_cnt_bound, clk, rst_n, 1'b1, ({1'b0, cnt_reg} <= last_idx),
        "point counter past last index")
    `SOBOL_ASSERT_NEXT(a_prep_busy, clk, rst_n, do_prep, busy,
        "prepare accepted but not busy")
    `SOBOL_ASSERT_NEXT(a_exh_sticky, clk, rst_n, exh_reg && !do_prep, exh_reg,
        "exhausted flag dropped without prepare")

endmodule

[rtl/sobol_prep.sv]
module sobol_prep
    import sobol_pkg::*;
#(
    parameter int MAX_BITS   = MAX_BITS_DEF
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               launch,
    input  logic [5:0]         lbits,
    input  logic [4:0]         degree,
    input  logic [16:0]        coeffs,
    input  logic               ident,
    input  logic [17:0]        m_value,
    input  logic [POINT_W-1:0] rd_data,
    output prep_port_t         port
);

    localparam int IDX_W = $clog2(MAX_BITS);

    localparam logic [2:0] ST_IDLE     = 3'd0;
    localparam logic [2:0] ST_FILL     = 3'd1;
    localparam logic [2:0] ST_REC_RD   = 3'd2;
    localparam logic [2:0] ST_REC_WAIT = 3'd3;
    localparam logic [2:0] ST_REC_WR   = 3'd4;

    logic [2:0]         state_reg, state_next;
    logic [IDX_W-1:0]   e_reg, e_next;
    logic [4:0]         j_reg, j_next;
    logic [4:0]         rdj_reg;
    logic               rdv_reg;
    logic [POINT_W-1:0] acc_reg;
    logic [POINT_W-1:0] acc_next;

    logic [5:0]         e6;
    logic [5:0]         s6;
    logic               last_e;
    logic               direct;
    logic [4:0]         shift;
    logic [5:0]         raddr6;
    logic [31:0]        coef32;
    logic [POINT_W-1:0] contrib;
    logic [4:0]         cbit;

    assign e6     = 6'(e_reg);
    assign s6     = {1'b0, degree};
    assign last_e = (e6 == (lbits - 6'd1));
    assign direct = ident || (e6 < s6);
    assign shift  = 5'(6'd31 - e6);
    assign raddr6 = e6 - s6 + {1'b0, j_reg};
    assign coef32 = {15'd0, coeffs};
    assign cbit   = rdj_reg - 5'd1;

    // first read is V[i-s], later reads are the inner taps
    always_comb
    begin
        if (rdj_reg == 5'd0)
        begin
            contrib  = rd_data ^ (rd_data >> degree);
            acc_next = contrib;
        end
        else
        begin
            contrib  = coef32[cbit] ? rd_data : '0;
            acc_next = acc_reg ^ contrib;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        e_next     = e_reg;
        j_next     = j_reg;
        port.busy  = (state_reg != ST_IDLE);
        port.we    = 1'b0;
        port.waddr = TAB_AW'(e_reg);
        port.wdata = ident ? (32'd1 << shift) : (32'(m_value) << shift);
        port.raddr = raddr6[TAB_AW-1:0];
        unique case (state_reg)
            ST_IDLE:
            begin
                if (launch)
                begin
                    state_next = ST_FILL;
                    e_next     = '0;
                end
            end
            ST_FILL:
            begin
                if (direct)
                begin
                    port.we = 1'b1;
                    if (last_e)
                    begin
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        e_next = e_reg + 1'b1;
                    end
                end
                else
                begin
                    state_next = ST_REC_RD;
                    j_next     = '0;
                end
            end
            ST_REC_RD:
            begin
                j_next = j_reg + 5'd1;
                if (j_reg == (degree - 5'd1))
                begin
                    state_next = ST_REC_WAIT;
                end
            end
            ST_REC_WAIT:
            begin
                state_next = ST_REC_WR;
            end
            ST_REC_WR:
            begin
                port.we    = 1'b1;
                port.wdata = acc_reg;
                if (last_e)
                begin
                    state_next = ST_IDLE;
                end
                else
                begin
                    e_next     = e_reg + 1'b1;
                    state_next = ST_FILL;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            e_reg     <= '0;
            j_reg     <= '0;
            rdv_reg   <= 1'b0;
            rdj_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            e_reg     <= e_next;
            j_reg     <= j_next;
            rdv_reg   <= (state_reg == ST_REC_RD);
            rdj_reg   <= j_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rdv_reg)
        begin
            acc_reg <= acc_next;
        end
    end

endmodule
